### rtl/ppbb_pkg.sv
// Shared types and codes for the ping-pong byte buffer.
`default_nettype none

package ppbb_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_CLEAR       = 3'd0;
    localparam logic [2:0] MODE_CLAIM_WRITE = 3'd1;
    localparam logic [2:0] MODE_APPEND      = 3'd2;
    localparam logic [2:0] MODE_COMMIT      = 3'd3;
    localparam logic [2:0] MODE_CLAIM_READ  = 3'd4;
    localparam logic [2:0] MODE_TAKE        = 3'd5;

    // Buffer status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    // Claim register value meaning no buffer held
    localparam logic [1:0] NO_SLOT = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_in;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       op_ignored;
        logic       any_empty;
        logic       any_ready;
        logic       all_empty;
    } t_out;

endpackage

`default_nettype wire

### rtl/ppbb_ram.sv
// Simple dual-port byte store with one write port and one registered read port.
`default_nettype none

module ppbb_ram #(
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/ping_pong_byte_buffer.sv
// Ping-pong byte buffer top level: two byte slots sharing one byte store.
// Each input transfer's result appears in the cycle after it; the result sits in the output register.
// Throughput: one operation per cycle unless output stalls, set by the single write port (append) and single
// registered read port (take) of the byte store; the read data forms the output register.
// Reset (synchronous, active low): statuses empty, counts and positions zero, no claims,
// output register empty. The byte store is not cleared and holds garbage until written.
`default_nettype none

module ping_pong_byte_buffer
    import ppbb_pkg::*;
#(
    parameter int SLOT_BYTES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    // Position and count must hold SLOT_BYTES itself
    localparam int PW    = $clog2(SLOT_BYTES + 1);
    // Offset within one slot
    localparam int AW    = $clog2(SLOT_BYTES);
    // Byte store address covering both slots
    localparam int DEPTH = 2 * SLOT_BYTES;
    localparam int MAW   = $clog2(DEPTH);

    // Control state, small enough to live in flops
    logic [PW-1:0] r_fill   [2];
    logic [PW-1:0] r_pos    [2];
    logic [1:0]    r_status [2];
    logic [1:0]    r_writer;
    logic [1:0]    r_reader;

    logic [PW-1:0] n_fill   [2];
    logic [PW-1:0] n_pos    [2];
    logic [1:0]    n_status [2];
    logic [1:0]    n_writer;
    logic [1:0]    n_reader;
    logic          n_ignored;
    logic          n_taken;

    // Output register; the data byte comes from the store's read register
    logic r_out_valid;
    logic r_taken;
    logic r_ignored;
    logic r_any_empty;
    logic r_any_ready;
    logic r_all_empty;

    logic           wr_en;
    logic [MAW-1:0] wr_addr;
    logic           rd_en;
    logic [MAW-1:0] rd_addr;
    logic [7:0]     rd_data;

    logic accept;

    // Take the next transfer whenever the output register frees up this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic          ws;
        logic          rs;
        logic [PW-1:0] pos;
        logic [PW:0]   pos_inc;
        logic [AW-1:0] off;

        n_fill    = r_fill;
        n_pos     = r_pos;
        n_status  = r_status;
        n_writer  = r_writer;
        n_reader  = r_reader;
        n_ignored = 1'b0;
        n_taken   = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        ws      = r_writer[0];
        rs      = r_reader[0];
        pos     = r_pos[rs];
        pos_inc = {1'b0, pos} + {{PW{1'b0}}, 1'b1};

        // Clamp a read position past the end onto the last byte of the slot
        if (pos < PW'(SLOT_BYTES)) begin
            off = pos[AW-1:0];
        end else begin
            off = AW'(SLOT_BYTES - 1);
        end
        rd_addr = MAW'(off) + (rs ? MAW'(SLOT_BYTES) : '0);
        wr_addr = MAW'(r_fill[ws][AW-1:0]) + (ws ? MAW'(SLOT_BYTES) : '0);

        unique case (i_in.mode)
            MODE_CLEAR: begin
                for (int s = 0; s < 2; s++) begin
                    n_fill[s]   = '0;
                    n_pos[s]    = '0;
                    n_status[s] = ST_EMPTY;
                end
                n_writer = NO_SLOT;
                n_reader = NO_SLOT;
            end
            MODE_CLAIM_WRITE: begin
                // Buffer 0 wins
                priority if (r_status[0] == ST_EMPTY) begin
                    n_writer    = 2'd0;
                    n_status[0] = ST_USED;
                end else if (r_status[1] == ST_EMPTY) begin
                    n_writer    = 2'd1;
                    n_status[1] = ST_USED;
                end else begin
                    n_ignored = 1'b1;
                end
            end
            MODE_APPEND: begin
                if (r_writer[1]) begin
                    n_ignored = 1'b1;
                end else if (r_fill[ws] < PW'(SLOT_BYTES)) begin
                    // A full slot drops the byte silently
                    wr_en      = 1'b1;
                    n_fill[ws] = r_fill[ws] + PW'(1);
                end
            end
            MODE_COMMIT: begin
                if (r_writer[1]) begin
                    n_ignored = 1'b1;
                end else if (r_fill[ws] != '0) begin
                    n_pos[ws]    = '0;
                    n_status[ws] = ST_READY;
                    n_writer     = NO_SLOT;
                end
            end
            MODE_CLAIM_READ: begin
                priority if (r_status[0] == ST_READY) begin
                    n_reader    = 2'd0;
                    n_status[0] = ST_USED;
                end else if (r_status[1] == ST_READY) begin
                    n_reader    = 2'd1;
                    n_status[1] = ST_USED;
                end else begin
                    n_ignored = 1'b1;
                end
            end
            MODE_TAKE: begin
                if (r_reader[1]) begin
                    n_ignored = 1'b1;
                end else begin
                    rd_en     = 1'b1;
                    n_taken   = 1'b1;
                    n_pos[rs] = pos_inc[PW-1:0];
                    if (pos_inc >= {1'b0, r_fill[rs]}) begin
                        // Drained: free the slot and move to a ready one if any
                        n_fill[rs]   = '0;
                        n_status[rs] = ST_EMPTY;
                        priority if (n_status[0] == ST_READY) begin
                            n_reader    = 2'd0;
                            n_status[0] = ST_USED;
                        end else if (n_status[1] == ST_READY) begin
                            n_reader    = 2'd1;
                            n_status[1] = ST_USED;
                        end else begin
                            // Nowhere to go: stay on the last byte and repeat it
                            n_pos[rs] = pos;
                        end
                    end
                end
            end
            default: begin
                // Unused modes do nothing
            end
        endcase

        // Memory accesses fire only on a transfer
        wr_en = wr_en && accept;
        rd_en = rd_en && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                r_fill[s]   <= '0;
                r_pos[s]    <= '0;
                r_status[s] <= ST_EMPTY;
            end
            r_writer    <= NO_SLOT;
            r_reader    <= NO_SLOT;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_pos       <= n_pos;
                r_status    <= n_status;
                r_writer    <= n_writer;
                r_reader    <= n_reader;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result flags: payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_taken     <= n_taken;
            r_ignored   <= n_ignored;
            r_any_empty <= (n_status[0] == ST_EMPTY) || (n_status[1] == ST_EMPTY);
            r_any_ready <= (n_status[0] == ST_READY) || (n_status[1] == ST_READY);
            r_all_empty <= (n_status[0] == ST_EMPTY) && (n_status[1] == ST_EMPTY);
        end
    end

    ppbb_ram #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.data_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out.data_out   = r_taken ? rd_data : 8'd0;
        o_out.data_valid = r_taken;
        o_out.op_ignored = r_ignored;
        o_out.any_empty  = r_any_empty;
        o_out.any_ready  = r_any_ready;
        o_out.all_empty  = r_all_empty;
    end

    // Every transfer in yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted operation produced no result");

    // A taken byte never comes with an ignored flag
    a_take_not_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.data_valid && o_out.op_ignored))
        else $error("result both taken and ignored");

    // Both empty means one empty and none ready
    a_flags_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.all_empty) |-> (o_out.any_empty && !o_out.any_ready))
        else $error("status flags disagree");

    // Fill never runs past the slot size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= PW'(SLOT_BYTES)) && (r_fill[1] <= PW'(SLOT_BYTES)))
        else $error("fill count beyond slot size");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the ping-pong byte buffer: directed and random transfers checked against a predictor.
module tb_top;
    import ppbb_pkg::*;

    localparam int SLOT           = 256;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_SETTLE     = 4;

    // Mode codes the block treats as no-ops
    localparam logic [2:0] MODE_SPARE    = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_item  = '0;
    logic in_ready;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out res_item;

    always #5 clk = ~clk;

    ping_pong_byte_buffer #(
        .SLOT_BYTES (SLOT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out       (res_item)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of both slots and the two claims.
    // byte_known marks store entries written since reset, so that the
    // stimulus never reads an entry the block leaves undefined.
    // ------------------------------------------------------------------
    logic [7:0]  byte_copy  [2*SLOT];
    bit          byte_known [2*SLOT];
    int unsigned fill_len   [2];
    int unsigned read_pos   [2];
    logic [1:0]  slot_state [2] = '{ST_EMPTY, ST_EMPTY};
    logic [1:0]  wr_slot = NO_SLOT;
    logic [1:0]  rd_slot = NO_SLOT;

    // Results still owed by the block, oldest first
    t_out buffer_replies [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int wr_target     = 4;
    int errors        = 0;
    int quiet_cycles  = 0;

    // Claim the first slot (slot 0 wins) in the wanted state; NO_SLOT if none.
    function automatic logic [1:0] grab_slot(input logic [1:0] wanted);
        for (int s = 0; s < 2; s++) begin
            if (slot_state[s] == wanted) begin
                slot_state[s] = ST_USED;
                return 2'(s);
            end
        end
        return NO_SLOT;
    endfunction

    // Advance the predicted buffers by one operation and return its result.
    function automatic t_out step_buffers(input t_in item);
        t_out        reply;
        logic [1:0]  s;
        logic [1:0]  successor;
        int unsigned pos;
        int unsigned base;
        reply = '0;
        case (item.mode)
            MODE_CLEAR: begin
                fill_len   = '{0, 0};
                read_pos   = '{0, 0};
                slot_state = '{ST_EMPTY, ST_EMPTY};
                wr_slot    = NO_SLOT;
                rd_slot    = NO_SLOT;
            end
            MODE_CLAIM_WRITE: begin
                s = grab_slot(ST_EMPTY);
                if (s == NO_SLOT) reply.op_ignored = 1'b1;
                else wr_slot = s;
            end
            MODE_APPEND: begin
                if (wr_slot == NO_SLOT) begin
                    reply.op_ignored = 1'b1;
                end else if (fill_len[wr_slot] < SLOT) begin
                    // a full slot drops the byte silently
                    base = wr_slot * SLOT + fill_len[wr_slot];
                    byte_copy[base]  = item.data_in;
                    byte_known[base] = 1'b1;
                    fill_len[wr_slot]++;
                end
            end
            MODE_COMMIT: begin
                if (wr_slot == NO_SLOT) begin
                    reply.op_ignored = 1'b1;
                end else if (fill_len[wr_slot] > 0) begin
                    // an empty fill keeps the writer claimed
                    read_pos[wr_slot]   = 0;
                    slot_state[wr_slot] = ST_READY;
                    wr_slot             = NO_SLOT;
                end
            end
            MODE_CLAIM_READ: begin
                s = grab_slot(ST_READY);
                if (s == NO_SLOT) reply.op_ignored = 1'b1;
                else rd_slot = s;
            end
            MODE_TAKE: begin
                if (rd_slot == NO_SLOT) begin
                    reply.op_ignored = 1'b1;
                end else begin
                    s    = rd_slot;
                    pos  = read_pos[s];
                    base = s * SLOT + ((pos < SLOT) ? pos : SLOT - 1);
                    reply.data_out   = byte_copy[base];
                    reply.data_valid = 1'b1;
                    pos++;
                    read_pos[s] = pos;
                    if (pos >= fill_len[s]) begin
                        // drained: free the slot, hop to a ready one or repeat the last byte
                        fill_len[s]   = 0;
                        slot_state[s] = ST_EMPTY;
                        successor     = grab_slot(ST_READY);
                        if (successor == NO_SLOT) read_pos[s] = pos - 1;
                        else rd_slot = successor;
                    end
                end
            end
            default: ;
        endcase
        reply.any_empty = (slot_state[0] == ST_EMPTY) || (slot_state[1] == ST_EMPTY);
        reply.any_ready = (slot_state[0] == ST_READY) || (slot_state[1] == ST_READY);
        reply.all_empty = (slot_state[0] == ST_EMPTY) && (slot_state[1] == ST_EMPTY);
        return reply;
    endfunction

    // Choose the next operation: mostly write/commit/read/take sequences that
    // follow the predicted state, with some clears and random noise mixed in.
    function automatic t_in pick_item();
        t_in         item;
        int unsigned roll;
        int unsigned pos;
        int unsigned base;
        item.data_in = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            item.mode = MODE_CLEAR;
        end else if (roll < 12) begin
            item.mode = 3'($urandom_range(1, 7));
        end else if (roll < 56) begin
            if (wr_slot == NO_SLOT) begin
                item.mode = MODE_CLAIM_WRITE;
            end else if (fill_len[wr_slot] < wr_target) begin
                item.mode = MODE_APPEND;
            end else begin
                item.mode = MODE_COMMIT;
                wr_target = $urandom_range(1, 24);
            end
        end else begin
            if (rd_slot == NO_SLOT || slot_state[rd_slot] == ST_EMPTY) item.mode = MODE_CLAIM_READ;
            else item.mode = MODE_TAKE;
        end
        // never read a store entry that was not written since reset
        if (item.mode == MODE_TAKE && rd_slot != NO_SLOT) begin
            pos  = read_pos[rd_slot];
            base = rd_slot * SLOT + ((pos < SLOT) ? pos : SLOT - 1);
            if (!byte_known[base]) item.mode = MODE_SPARE;
        end
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one item, hold it until the transfer, then idle for a random gap that may be empty.
    // ------------------------------------------------------------------
    task automatic send_item(input t_in item);
        int gap;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        buffer_replies.push_back(step_buffers(item));
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [2:0] mode, input logic [7:0] data);
        t_in item;
        item.mode    = mode;
        item.data_in = data;
        send_item(item);
    endtask

    // Hold the sender until every owed result has come back.
    task automatic wait_all_replies();
        in_valid <= 1'b0;
        while (buffer_replies.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want, got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    task automatic check_reply(input t_out got);
        t_out want;
        if (buffer_replies.size() == 0) begin
            errors++;
            $display("%0t: result %h with none expected", $time, got);
            return;
        end
        want = buffer_replies.pop_front();
        check_field("data_out",   want.data_out,   got.data_out);
        check_field("data_valid", want.data_valid, got.data_valid);
        check_field("op_ignored", want.op_ignored, got.op_ignored);
        check_field("any_empty",  want.any_empty,  got.any_empty);
        check_field("any_ready",  want.any_ready,  got.any_ready);
        check_field("all_empty",  want.all_empty,  got.all_empty);
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid === 1'b1 && res_ready) check_reply(res_item);
    end

    // Watchdog: end the run if no transfer happens on either side for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Operations with no claimed slot or no candidate, and the unused modes
    task automatic test_unclaimed_ops();
        issue(MODE_APPEND,     8'h3C);
        issue(MODE_COMMIT,     8'h00);
        issue(MODE_TAKE,       8'h00);
        issue(MODE_CLAIM_READ, 8'h00);
        issue(MODE_SPARE,      8'hFF);
        issue(MODE_SPARE_HI,   8'h00);
    endtask

    // Commit with nothing appended keeps the writer; a real commit releases it
    task automatic test_empty_commit();
        issue(MODE_CLAIM_WRITE, 8'h00);
        issue(MODE_COMMIT,      8'h00);
        issue(MODE_APPEND,      8'h00);
        issue(MODE_APPEND,      8'hFF);
        issue(MODE_COMMIT,      8'h00);
        issue(MODE_COMMIT,      8'h00);
    endtask

    // Fill both slots, check slot 0 priority, drain across slots and repeat the last byte
    task automatic test_ping_pong();
        issue(MODE_CLEAR,       8'h00);
        issue(MODE_CLAIM_WRITE, 8'h00);
        issue(MODE_APPEND,      8'hA5);
        issue(MODE_APPEND,      8'h5A);
        issue(MODE_COMMIT,      8'h00);
        issue(MODE_CLAIM_WRITE, 8'h00);
        issue(MODE_APPEND,      8'h81);
        issue(MODE_COMMIT,      8'h00);
        issue(MODE_CLAIM_WRITE, 8'h00);
        issue(MODE_CLAIM_READ,  8'h00);
        issue(MODE_TAKE,        8'h00);
        issue(MODE_TAKE,        8'h00);
        issue(MODE_TAKE,        8'h00);
        issue(MODE_TAKE,        8'h00);
        issue(MODE_CLEAR,       8'h00);
    endtask

    // Overfill one slot, then read it out and one past the end
    task automatic test_full_slot();
        issue(MODE_CLAIM_WRITE, 8'h00);
        for (int i = 0; i < SLOT + 2; i++) issue(MODE_APPEND, 8'($urandom_range(0, 255)));
        issue(MODE_COMMIT,     8'h00);
        issue(MODE_CLAIM_READ, 8'h00);
        for (int i = 0; i < SLOT + 1; i++) issue(MODE_TAKE, 8'h00);
        issue(MODE_CLEAR, 8'h00);
    endtask

    // Stop the output for a long stretch while the input keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 120;
        repeat (40) send_item(pick_item());
        wait_all_replies();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) send_item(pick_item());
        wait_all_replies();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unclaimed_ops();
        test_empty_commit();
        test_ping_pong();
        test_full_slot();
        wait_all_replies();
        test_backpressure();
        test_random(100, 0, 0);
        test_random(100, 82, 0);
        test_random(100, 0, 82);
        test_random(100, 15, 15);

        // let any stray result show up before the verdict
        repeat (END_SETTLE) @(posedge clk);
        if (buffer_replies.size() != 0) errors++;
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
